[hw/rtl/uart_frame_deframer_macros.svh]
// assertion macros for the frame deframer
// needs a clock named clk and a reset named rst in the module that uses them
`ifndef UART_FRAME_DEFRAMER_MACROS_SVH
`define UART_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define UFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked at every edge, reset included
`define UFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UFD_ASSERT(label, prop, msg)
`define UFD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hw/rtl/ufd_pkg.sv]
// shared types and constants of the frame deframer
// used by ufd_ctrl, ufd_datapath and uart_frame_deframer
package ufd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h7A;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } ufd_reg_t;

  typedef enum logic [1:0] {
    S_RECV,
    S_READ,
    S_SHOW
  } ufd_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // rx item accepted this cycle
    logic rd_first;  // start reading the frame at position 0
    logic advance;   // shown byte taken, read the next one
  } ufd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_good;  // current rx byte closes a frame with a good checksum
    logic at_last;     // shown byte is the final one of the frame
  } ufd_sts_t;

endpackage

[hw/rtl/ufd_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module ufd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/ufd_ctrl.sv]
// controller state machine of the frame deframer: receive, then replay a frame
// depends on ufd_pkg and uart_frame_deframer_macros.svh
`include "uart_frame_deframer_macros.svh"

module ufd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  output logic              frame_valid,
  input  logic              frame_stall,
  input  ufd_pkg::ufd_sts_t sts,
  output ufd_pkg::ufd_cmd_t cmd
);

  ufd_pkg::ufd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ufd_pkg::S_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ufd_pkg::S_RECV: begin
        if (rx_valid && sts.frame_good) begin
          state_next = ufd_pkg::S_READ;
        end
      end
      ufd_pkg::S_READ: begin
        state_next = ufd_pkg::S_SHOW;
      end
      ufd_pkg::S_SHOW: begin
        if (!frame_stall && sts.at_last) begin
          state_next = ufd_pkg::S_RECV;
        end
      end
      default: state_next = ufd_pkg::S_RECV;
    endcase
  end

  always_comb begin
    rx_stall     = 1'b1;
    frame_valid  = 1'b0;
    cmd          = '0;
    unique case (state)
      ufd_pkg::S_RECV: begin
        rx_stall = 1'b0;
        cmd.take = rx_valid;
      end
      ufd_pkg::S_READ: begin
        cmd.rd_first = 1'b1;
      end
      ufd_pkg::S_SHOW: begin
        frame_valid = 1'b1;
        cmd.advance = !frame_stall && !sts.at_last;
      end
      default: begin
        rx_stall = 1'b1;
      end
    endcase
  end

  // never take rx bytes while a frame is being replayed
  `UFD_ASSERT(a_no_rx_during_replay, !(frame_valid && !rx_stall), "rx open during replay")
  // taking the final byte ends the replay
  `UFD_ASSERT(a_last_ends_replay, (frame_valid && !frame_stall && sts.at_last) |=> !frame_valid, "replay ran past last byte")
  // a good frame is shown once the controller has passed from S_READ into S_SHOW
  `UFD_ASSERT(a_good_frame_shown, (cmd.take && sts.frame_good) |=> ##1 frame_valid, "good frame not replayed")
  `UFD_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !frame_valid, "frame valid after reset")

endmodule

[hw/rtl/ufd_datapath.sv]
// datapath of the frame deframer: markers, frame store, count, running checksum
// depends on ufd_pkg and ufd_ram
module ufd_datapath #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [ufd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ufd_pkg::BYTE_W-1:0]          cfg_wdata,
  input  logic [ufd_pkg::BYTE_W-1:0]          rx_byte,
  input  ufd_pkg::ufd_cmd_t                   cmd,
  output ufd_pkg::ufd_sts_t                   sts,
  output logic [ufd_pkg::BYTE_W-1:0]          frame_byte,
  output logic [ufd_pkg::INDEX_W-1:0]         byte_index,
  output logic                                last_byte
);

  localparam int unsigned AW = $clog2(MAX_FRAME);
  localparam logic [AW-1:0] LAST_POS = AW'(MAX_FRAME - 1);

  logic [ufd_pkg::BYTE_W-1:0] start_marker, end_marker;
  logic [AW-1:0]              count;       // bytes stored, 0 when idle
  logic [ufd_pkg::BYTE_W-1:0] sum;         // sum of positions 1..count-1
  logic [ufd_pkg::BYTE_W-1:0] prev;        // newest stored byte
  logic [ufd_pkg::BYTE_W-1:0] length;      // byte at position 1
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              rd_ptr;

  logic                       opening, closing, sum_ok, wr_en, rd_en;
  logic [AW-1:0]              rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= ufd_pkg::START_MARKER_RST;
      end_marker   <= ufd_pkg::END_MARKER_RST;
    end else if (cfg_wr_en) begin
      unique case (ufd_pkg::ufd_reg_t'(cfg_index))
        ufd_pkg::REG_START_MARKER: start_marker <= cfg_wdata;
        ufd_pkg::REG_END_MARKER:   end_marker   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign opening = (count == '0) && (rx_byte == start_marker);
  // new byte is position count, so the frame has count+1 bytes and L must be count-2
  assign closing = (count >= AW'(2)) && (rx_byte == end_marker) &&
                   (length == (ufd_pkg::BYTE_W'(count) - ufd_pkg::BYTE_W'(2)));
  // sum still holds the checksum byte itself, take it back out
  assign sum_ok  = ((sum - prev) == prev);

  assign sts.frame_good = closing && sum_ok;
  assign sts.at_last    = (rd_ptr == last_idx);

  assign wr_en = cmd.take && (opening || (count != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.take) begin
      if (count == '0) begin
        if (opening) begin
          count <= AW'(1);
        end
      end else if (closing || count == LAST_POS) begin
        count <= '0;
      end else begin
        count <= count + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (count == '0) begin
        sum <= '0;
      end else if (!closing) begin
        sum  <= sum + rx_byte;
        prev <= rx_byte;
        if (count == AW'(1)) begin
          length <= rx_byte;
        end
      end else begin
        last_idx <= count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      rd_ptr <= '0;
    end else if (cmd.advance) begin
      rd_ptr <= rd_ptr + AW'(1);
    end
  end

  assign rd_en   = cmd.rd_first || cmd.advance;
  assign rd_addr = cmd.advance ? (rd_ptr + AW'(1)) : '0;

  ufd_ram #(
    .WIDTH (ufd_pkg::BYTE_W),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count),
    .wdata (rx_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (frame_byte)
  );

  assign byte_index = ufd_pkg::INDEX_W'(rd_ptr);
  assign last_byte  = sts.at_last;

endmodule

[hw/rtl/uart_frame_deframer.sv]
// Frame deframer for a received byte stream.
// rx channel (rx_valid/rx_stall/rx_byte) takes one byte per cycle while the
// block is receiving. Outside a frame a byte equal to start_marker opens one;
// inside a frame bytes are stored until the end marker arrives with a length
// byte that matches the count. A frame with a good modulo-256 checksum is
// replayed on the frame channel (frame_valid/frame_stall, frame_byte,
// byte_index, last_byte), start marker first, last_byte on the final byte.
// Timing: after the end byte is taken the controller passes through S_READ,
// which reads position 0 of the frame store, into S_SHOW, where the first
// byte is valid; the remaining bytes follow at one per cycle while not stalled.
// rx_stall stays high during replay. A stalled frame byte holds; the replay
// resumes when frame_stall drops. Bad checksums and frames longer than
// MAX_FRAME bytes are dropped without output.
// Reset (rst, synchronous) sets start_marker 0x7A and end_marker 0x55 and
// returns to waiting for a start marker; stored bytes are not cleared.
// cfg_wr_en writes cfg_wdata to start_marker (index 0) or end_marker (index 1).
module uart_frame_deframer #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ufd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ufd_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          rx_valid,
  output logic                          rx_stall,
  input  logic [ufd_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          frame_valid,
  input  logic                          frame_stall,
  output logic [ufd_pkg::BYTE_W-1:0]    frame_byte,
  output logic [ufd_pkg::INDEX_W-1:0]   byte_index,
  output logic                          last_byte
);

  ufd_pkg::ufd_cmd_t cmd;
  ufd_pkg::ufd_sts_t sts;

  ufd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  ufd_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last_byte  (last_byte)
  );

endmodule
